// File: src/evr_pkg.sv
// Shared types, constants and the quarter-wave sine table for the Euler vertex rotator.
// Used by the channel interfaces, the matrix builder, the transform pipeline and the top level.
package evr_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int QUARTER_UNITS    = 5760;
    localparam int FULL_UNITS       = 23040;
    localparam longint HALF_PI_Q30  = 64'd1686629713;
    localparam int ONE_Q16          = 65536;

    // Table index covers 0..SINE_TABLE_DEPTH.
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int DIVISOR = 2 * QUARTER_UNITS;
    localparam int NUM_W   = $clog2(DIVISOR * (SINE_TABLE_DEPTH + 1));

    // Reciprocal of the index divisor, exact for every numerator below 2**NUM_W.
    localparam int RECIP_SH     = NUM_W + $clog2(DIVISOR);
    localparam int RECIP_W      = RECIP_SH - $clog2(DIVISOR) + 1;
    localparam longint RECIP_M  = ((longint'(1) << RECIP_SH) + DIVISOR - 1) / DIVISOR;

    // Configuration register indexes.
    localparam logic [1:0] REG_ANGLE_X = 2'd0;
    localparam logic [1:0] REG_ANGLE_Y = 2'd1;
    localparam logic [1:0] REG_ANGLE_Z = 2'd2;

    typedef logic signed [17:0] t_coef;
    typedef t_coef t_matrix [0:8];
    typedef logic [16:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_z;
        logic signed [15:0] bitan_x;
        logic signed [15:0] bitan_y;
        logic signed [15:0] bitan_z;
    } t_vertex;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [15:0] out_norm_x;
        logic signed [15:0] out_norm_y;
        logic signed [15:0] out_norm_z;
        logic signed [15:0] out_tan_x;
        logic signed [15:0] out_tan_y;
        logic signed [15:0] out_tan_z;
        logic signed [15:0] out_bitan_x;
        logic signed [15:0] out_bitan_y;
        logic signed [15:0] out_bitan_z;
    } t_result;

    // Integer Taylor series for sin over one quarter wave, Q16 entries.
    function automatic t_sine_rom f_build_sine();
        t_sine_rom rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] acc;
        logic signed [63:0] v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'(i) * 64'(HALF_PI_Q30)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            acc  = $signed(x);
            for (int k = 1; k <= 12; k++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
            end
            v = (acc >= 0) ? ((acc + 64'sd8192) >>> 14) : 64'sd0;
            if (v > 64'(ONE_Q16)) begin
                v = 64'(ONE_Q16);
            end
            rom[i] = 17'(v);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

    // Shift right by 16 bits, then saturate to 32 bits; rounding is left to the caller.
    function automatic logic signed [31:0] f_sat_pos(input logic signed [51:0] s);
        logic signed [35:0] sh;
        sh = 36'(s >>> 16);
        if (sh > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (sh < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(sh);
    endfunction

    function automatic logic signed [15:0] f_sat_dir(input logic signed [35:0] s);
        logic signed [19:0] sh;
        sh = 20'(s >>> 16);
        if (sh > 20'sd32767) begin
            return 16'sh7fff;
        end else if (sh < -20'sd32768) begin
            return 16'sh8000;
        end
        return 16'(sh);
    endfunction

endpackage

// File: src/evr_in_if.sv
// Vertex input channel: valid/ready handshake carrying one vertex per beat.
// Depends on evr_pkg for the payload type.
interface evr_in_if import evr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_vertex data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/evr_out_if.sv
// Result output channel: valid/ready handshake carrying one rotated vertex per beat.
// Depends on evr_pkg for the payload type.
interface evr_out_if import evr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/evr_matrix.sv
// Angle registers and the sequencer that rebuilds the Z*Y*X rotation matrix.
// Depends on evr_pkg for the sine table, matrix type and register indexes.
module evr_matrix import evr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output t_matrix     o_mat,
    output logic        o_busy
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ANGLE = 6'b000010,
        ST_SPLIT = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_LOOK  = 6'b010000,
        ST_MUL   = 6'b100000
    } t_state;

    localparam logic [3:0] LAST_STEP = 4'd13;

    t_state r_state;
    logic signed [15:0] r_ang [0:2];
    logic [2:0]  r_k;
    logic [14:0] r_red;
    logic [1:0]  r_quad;
    logic [NUM_W-1:0] r_rem;
    logic [IDX_W-1:0] r_idx;
    t_coef r_sin [0:5];
    logic [3:0]  r_step;
    logic        r_pvalid;
    logic [3:0]  r_pstep;
    logic signed [53:0] r_prod;
    logic signed [35:0] r_t1;
    logic signed [35:0] r_t2;
    logic signed [35:0] r_e;
    t_coef r_mat [0:8];

    logic cfg_hit;
    logic signed [17:0] n_ang_sum;
    logic [16:0] n_wrap;
    logic [14:0] n_red;
    logic [1:0]  n_quad;
    logic [12:0] n_off;
    logic [NUM_W+RECIP_W-1:0] n_recip;
    logic [IDX_W-1:0] n_quot;
    logic [IDX_W-1:0] n_idx;
    logic [16:0] n_mag;
    t_coef n_sin;
    logic signed [35:0] n_opa;
    t_coef n_opb;
    logic signed [37:0] n_rnd16;
    logic signed [54:0] n_sum3;
    logic signed [22:0] n_rnd32;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == REG_ANGLE_X || i_cfg_idx == REG_ANGLE_Y
                                  || i_cfg_idx == REG_ANGLE_Z);

    // Reduce angle (plus a quarter turn for cosine) into one full turn.
    always_comb begin
        n_ang_sum = 18'(r_ang[r_k[2:1]]) + (r_k[0] ? 18'sd5760 : 18'sd0)
                  + 18'sd46080;
        n_wrap = 17'(n_ang_sum);
        if (n_wrap >= 17'(3 * FULL_UNITS)) begin
            n_red = 15'(n_wrap - 17'(3 * FULL_UNITS));
        end else if (n_wrap >= 17'(2 * FULL_UNITS)) begin
            n_red = 15'(n_wrap - 17'(2 * FULL_UNITS));
        end else if (n_wrap >= 17'(FULL_UNITS)) begin
            n_red = 15'(n_wrap - 17'(FULL_UNITS));
        end else begin
            n_red = 15'(n_wrap);
        end
    end

    always_comb begin
        if (r_red >= 15'(3 * QUARTER_UNITS)) begin
            n_quad = 2'd3;
            n_off  = 13'(r_red - 15'(3 * QUARTER_UNITS));
        end else if (r_red >= 15'(2 * QUARTER_UNITS)) begin
            n_quad = 2'd2;
            n_off  = 13'(r_red - 15'(2 * QUARTER_UNITS));
        end else if (r_red >= 15'(QUARTER_UNITS)) begin
            n_quad = 2'd1;
            n_off  = 13'(r_red - 15'(QUARTER_UNITS));
        end else begin
            n_quad = 2'd0;
            n_off  = 13'(r_red);
        end
    end

    // Table index by reciprocal multiplication instead of a divider.
    assign n_recip = (NUM_W+RECIP_W)'(r_rem) * (NUM_W+RECIP_W)'(RECIP_M);
    assign n_quot  = IDX_W'(n_recip >> RECIP_SH);

    always_comb begin
        n_idx = (r_idx > IDX_W'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH) : r_idx;
        n_mag = r_quad[0] ? SINE_ROM[IDX_W'(SINE_TABLE_DEPTH) - n_idx] : SINE_ROM[n_idx];
        n_sin = r_quad[1] ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
    end

    // Sine slots: 0 sx, 1 cx, 2 sy, 3 cy, 4 sz, 5 cz.
    always_comb begin
        case (r_step)
            4'd0:    begin n_opa = 36'(r_sin[5]); n_opb = r_sin[3]; end
            4'd1:    begin n_opa = 36'(r_sin[3]); n_opb = r_sin[0]; end
            4'd2:    begin n_opa = 36'(r_sin[3]); n_opb = r_sin[1]; end
            4'd3:    begin n_opa = 36'(r_sin[4]); n_opb = r_sin[3]; end
            4'd4:    begin n_opa = 36'(r_sin[5]); n_opb = r_sin[2]; end
            4'd5:    begin n_opa = 36'(r_sin[4]); n_opb = r_sin[2]; end
            4'd6:    begin n_opa = 36'(r_sin[4]); n_opb = r_sin[1]; end
            4'd7:    begin n_opa = r_t1;          n_opb = r_sin[0]; end
            4'd8:    begin n_opa = 36'(r_sin[4]); n_opb = r_sin[0]; end
            4'd9:    begin n_opa = r_t1;          n_opb = r_sin[1]; end
            4'd10:   begin n_opa = 36'(r_sin[5]); n_opb = r_sin[1]; end
            4'd11:   begin n_opa = r_t2;          n_opb = r_sin[0]; end
            4'd12:   begin n_opa = 36'(r_sin[5]); n_opb = r_sin[0]; end
            4'd13:   begin n_opa = r_t2;          n_opb = r_sin[1]; end
            default: begin n_opa = '0;            n_opb = '0;       end
        endcase
    end

    // Two-factor products round by 16 bits; three-factor sums round by 32.
    always_comb begin
        n_rnd16 = 38'((r_prod + 54'sd32768) >>> 16);
        if (r_pstep == 4'd7 || r_pstep == 4'd13) begin
            n_sum3 = 55'(r_prod) - (55'(r_e) <<< 16);
        end else begin
            n_sum3 = 55'(r_prod) + (55'(r_e) <<< 16);
        end
        n_rnd32 = 23'((n_sum3 + 55'sd2147483648) >>> 32);
    end

    function automatic t_coef f_sat18_a(input logic signed [37:0] v);
        if (v > 38'sd131071) return 18'sh1ffff;
        if (v < -38'sd131072) return 18'sh20000;
        return 18'(v);
    endfunction

    function automatic t_coef f_sat18_b(input logic signed [22:0] v);
        if (v > 23'sd131071) return 18'sh1ffff;
        if (v < -23'sd131072) return 18'sh20000;
        return 18'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= '0;
            r_step   <= '0;
            r_pvalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_ang[i] <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                r_mat[i] <= ((i % 4) == 0) ? 18'(ONE_Q16) : '0;
            end
        end else begin
            r_pvalid <= 1'b0;
            if (r_pvalid) begin
                case (r_pstep)
                    4'd0:    r_mat[0] <= f_sat18_a(n_rnd16);
                    4'd1:    r_mat[7] <= f_sat18_a(n_rnd16);
                    4'd2:    r_mat[8] <= f_sat18_a(n_rnd16);
                    4'd3:    r_mat[3] <= f_sat18_a(n_rnd16);
                    4'd4:    r_t1 <= 36'(r_prod);
                    4'd5:    r_t2 <= 36'(r_prod);
                    4'd7:    r_mat[1] <= f_sat18_b(n_rnd32);
                    4'd9:    r_mat[2] <= f_sat18_b(n_rnd32);
                    4'd11:   r_mat[4] <= f_sat18_b(n_rnd32);
                    4'd13:   r_mat[5] <= f_sat18_b(n_rnd32);
                    default: r_e <= 36'(r_prod);
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                end
                ST_ANGLE: begin
                    r_red   <= n_red;
                    r_state <= ST_SPLIT;
                end
                ST_SPLIT: begin
                    r_quad  <= n_quad;
                    r_rem   <= NUM_W'(n_off) * NUM_W'(2 * SINE_TABLE_DEPTH)
                             + NUM_W'(QUARTER_UNITS);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_idx   <= n_quot;
                    r_state <= ST_LOOK;
                end
                ST_LOOK: begin
                    r_sin[r_k] <= n_sin;
                    if (r_k == 3'd5) begin
                        r_step  <= '0;
                        r_state <= ST_MUL;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_ANGLE;
                    end
                end
                ST_MUL: begin
                    r_prod   <= 54'(n_opa) * 54'(n_opb);
                    r_pstep  <= r_step;
                    r_pvalid <= 1'b1;
                    if (r_step == 4'd0) begin
                        r_mat[6] <= -r_sin[2];
                    end
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // A new angle restarts the rebuild from the first sine.
            if (cfg_hit) begin
                r_ang[i_cfg_idx] <= $signed(i_cfg_data);
                r_k      <= '0;
                r_pvalid <= 1'b0;
                r_state  <= ST_ANGLE;
            end
        end
    end

    assign o_busy = (r_state != ST_IDLE) || r_pvalid;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            o_mat[i] = r_mat[i];
        end
    end

endmodule

// File: src/evr_xform.sv
// Three-stage pipeline that multiplies position, normal, tangent and bitangent by the matrix.
// Depends on evr_pkg and on the evr_in_if / evr_out_if channels.
module evr_xform import evr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_matrix    i_mat,
    input  logic       i_hold,
    evr_in_if.sink     i_vtx,
    evr_out_if.source  o_res
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    logic signed [49:0] r_pp [0:2][0:2];
    logic signed [33:0] r_dp [0:2][0:2][0:2];
    logic signed [51:0] r_ps [0:2];
    logic signed [35:0] r_ds [0:2][0:2];
    logic signed [31:0] r_op [0:2];
    logic signed [15:0] r_od [0:2][0:2];

    logic signed [31:0] pv [0:2];
    logic signed [15:0] dv [0:2][0:2];

    assign rdy3 = !r_v3 || o_res.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_vtx.ready = rdy1 && !i_hold;

    always_comb begin
        pv[0] = i_vtx.data.pos_x;    pv[1] = i_vtx.data.pos_y;    pv[2] = i_vtx.data.pos_z;
        dv[0][0] = i_vtx.data.norm_x;  dv[0][1] = i_vtx.data.norm_y;
        dv[0][2] = i_vtx.data.norm_z;
        dv[1][0] = i_vtx.data.tan_x;   dv[1][1] = i_vtx.data.tan_y;
        dv[1][2] = i_vtx.data.tan_z;
        dv[2][0] = i_vtx.data.bitan_x; dv[2][1] = i_vtx.data.bitan_y;
        dv[2][2] = i_vtx.data.bitan_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_vtx.valid && i_vtx.ready;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Stage one: one product per matrix coefficient and lane.
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pp[r][c] <= 50'(i_mat[3 * r + c]) * 50'(pv[c]);
                    for (int g = 0; g < 3; g++) begin
                        r_dp[g][r][c] <= 34'(i_mat[3 * r + c]) * 34'(dv[g][c]);
                    end
                end
            end
        end
    end

    // Stage two: exact row sums with the half-up rounding constant folded in.
    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            for (int r = 0; r < 3; r++) begin
                r_ps[r] <= 52'(r_pp[r][0]) + 52'(r_pp[r][1]) + 52'(r_pp[r][2])
                         + 52'sd32768;
                for (int g = 0; g < 3; g++) begin
                    r_ds[g][r] <= 36'(r_dp[g][r][0]) + 36'(r_dp[g][r][1])
                                + 36'(r_dp[g][r][2]) + 36'sd32768;
                end
            end
        end
    end

    // Stage three: shift down and saturate into the output register.
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            for (int r = 0; r < 3; r++) begin
                r_op[r] <= f_sat_pos(r_ps[r]);
                for (int g = 0; g < 3; g++) begin
                    r_od[g][r] <= f_sat_dir(r_ds[g][r]);
                end
            end
        end
    end

    assign o_res.valid = r_v3;

    always_comb begin
        o_res.data.out_pos_x   = r_op[0];
        o_res.data.out_pos_y   = r_op[1];
        o_res.data.out_pos_z   = r_op[2];
        o_res.data.out_norm_x  = r_od[0][0];
        o_res.data.out_norm_y  = r_od[0][1];
        o_res.data.out_norm_z  = r_od[0][2];
        o_res.data.out_tan_x   = r_od[1][0];
        o_res.data.out_tan_y   = r_od[1][1];
        o_res.data.out_tan_z   = r_od[1][2];
        o_res.data.out_bitan_x = r_od[2][0];
        o_res.data.out_bitan_y = r_od[2][1];
        o_res.data.out_bitan_z = r_od[2][2];
    end

endmodule

// File: src/euler_vertex_rotator.sv
// Euler vertex rotator: an accepted vertex beat passes through the three-stage
// multiply/sum/saturate pipeline to its result beat, one vertex per cycle while the
// output is ready and no matrix rebuild runs. An angle write rebuilds the matrix in a
// sequencer (angle, split, divide and lookup per sine value, fourteen multiply steps,
// then the last product retires); vertex beats are held off until it finishes.
// Synchronous active-low reset clears the angles to zero, loads the identity matrix
// and empties the pipeline.
module euler_vertex_rotator import evr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    evr_in_if.sink      i_vtx,
    evr_out_if.source   o_res
);

    t_matrix mat;
    logic    mat_busy;

    evr_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_mat      (mat),
        .o_busy     (mat_busy)
    );

    evr_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat),
        .i_hold  (mat_busy),
        .i_vtx   (i_vtx),
        .o_res   (o_res)
    );

endmodule
